// ===== rtl/core/gzhp_pkg.sv =====
// ---------------------------------------------------------------------------
// gzhp_pkg: shared types and constants of the gzip header parser
// Byte classification record, result record, status codes and header constants.
// ---------------------------------------------------------------------------
package gzhp_pkg;

  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned LIMIT_BITS    = 16;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  MAGIC_FIRST      = 8'h1F;
  localparam logic [7:0]  MAGIC_SECOND     = 8'h8B;
  localparam logic [3:0]  METHOD_DEFLATE   = 4'd8;
  localparam logic [POSITION_BITS:0] FIXED_LEN = (POSITION_BITS + 1)'(10);
  localparam logic [LIMIT_BITS-1:0]  SCAN_LIMIT_RESET = LIMIT_BITS'(4096);

  localparam logic [1:0] STATUS_NOT_GZIP = 2'd0;
  localparam logic [1:0] STATUS_ACCEPT   = 2'd1;
  localparam logic [1:0] STATUS_REJECT   = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_magic1;
    logic       is_magic2;
    logic       method_ok;
    logic       rsvd_ok;
    logic       is_zero;
  } item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [POSITION_BITS-1:0] length;
    logic [4:0]               flags;
  } result_t;

endpackage

// ===== rtl/core/gzhp_front.sv =====
// ---------------------------------------------------------------------------
// gzhp_front: byte intake and classification
// Tags each accepted byte with its header checks and holds it in a short queue.
// ---------------------------------------------------------------------------
module gzhp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output logic              item_valid_o,
  input  logic              item_take_i,
  output gzhp_pkg::item_t   item_o
);

  gzhp_pkg::item_t                         mem_q [gzhp_pkg::QUEUE_DEPTH];
  gzhp_pkg::item_t                         item_in;
  logic [gzhp_pkg::QUEUE_PTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [gzhp_pkg::QUEUE_PTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [gzhp_pkg::QUEUE_CNT_W-1:0]        cnt_q, cnt_d;
  logic                                    wr_en, rd_en;

  always_comb begin
    item_in.data      = data_byte_i;
    item_in.last      = last_byte_i;
    item_in.is_magic1 = (data_byte_i == gzhp_pkg::MAGIC_FIRST);
    item_in.is_magic2 = (data_byte_i == gzhp_pkg::MAGIC_SECOND);
    item_in.method_ok = (data_byte_i[3:0] == gzhp_pkg::METHOD_DEFLATE);
    item_in.rsvd_ok   = (data_byte_i[7:5] == 3'b000);
    item_in.is_zero   = (data_byte_i == 8'h00);
  end

  assign full_o       = (cnt_q == gzhp_pkg::QUEUE_CNT_W'(gzhp_pkg::QUEUE_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign wr_en        = push_i && !full_o;
  assign rd_en        = item_take_i && item_valid_o;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ===== rtl/core/gzhp_back.sv =====
// ---------------------------------------------------------------------------
// gzhp_back: header phase sequencer and result buffer
// Walks header fields one byte per cycle unless stalled; buffers each verdict.
// ---------------------------------------------------------------------------
module gzhp_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [gzhp_pkg::LIMIT_BITS-1:0]    scan_limit_i,
  input  logic                               item_valid_i,
  output logic                               item_take_o,
  input  gzhp_pkg::item_t                    item_i,
  output logic                               empty_o,
  input  logic                               pop_i,
  output gzhp_pkg::result_t                  result_o
);

  localparam logic [3:0] PH_MAGIC1  = 4'd0;
  localparam logic [3:0] PH_MAGIC2  = 4'd1;
  localparam logic [3:0] PH_METHOD  = 4'd2;
  localparam logic [3:0] PH_FLAGS   = 4'd3;
  localparam logic [3:0] PH_FIXED   = 4'd4;
  localparam logic [3:0] PH_XLEN_LO = 4'd5;
  localparam logic [3:0] PH_XLEN_HI = 4'd6;
  localparam logic [3:0] PH_EXTRA   = 4'd7;
  localparam logic [3:0] PH_NAME    = 4'd8;
  localparam logic [3:0] PH_COMMENT = 4'd9;
  localparam logic [3:0] PH_HCRC    = 4'd10;
  localparam logic [3:0] PH_NONE    = 4'd15;

  localparam int unsigned PB = gzhp_pkg::POSITION_BITS;

  logic [3:0]     phase_q, phase_d;
  logic [PB-1:0]  pos_q, pos_d;
  logic [15:0]    skip_q, skip_d;
  logic [4:0]     flags_q, flags_d;
  logic           verdict_q, verdict_d;

  gzhp_pkg::result_t res_mem_q [2];
  gzhp_pkg::result_t res_d;
  logic              res_wr;
  logic              res_rd;
  logic              res_wp_q, res_rp_q;
  logic [1:0]        res_cnt_q, res_cnt_d;

  logic [PB:0]    len;
  logic           proc;
  logic           decided;
  logic [1:0]     status;
  logic           complete;
  logic           from_valid;
  logic [3:0]     from_ph;
  logic [3:0]     nxt;
  logic [15:0]    skip_dec;

  assign proc        = item_valid_i && ((res_cnt_q != 2'd2) || pop_i);
  assign item_take_o = proc;
  assign len         = {1'b0, pos_q} + 1'b1;
  assign skip_dec    = skip_q - 1'b1;

  always_comb begin
    if (from_ph < PH_XLEN_LO && flags_q[2]) begin
      nxt = PH_XLEN_LO;
    end else if (from_ph < PH_NAME && flags_q[3]) begin
      nxt = PH_NAME;
    end else if (from_ph < PH_COMMENT && flags_q[4]) begin
      nxt = PH_COMMENT;
    end else if (from_ph < PH_HCRC && flags_q[1]) begin
      nxt = PH_HCRC;
    end else begin
      nxt = PH_NONE;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    skip_d     = skip_q;
    flags_d    = flags_q;
    verdict_d  = verdict_q;
    decided    = 1'b0;
    status     = gzhp_pkg::STATUS_NOT_GZIP;
    complete   = 1'b0;
    from_valid = 1'b0;
    from_ph    = PH_NONE;
    res_wr     = 1'b0;
    res_d      = '0;

    if (proc && !verdict_q) begin
      pos_d = (&pos_q) ? pos_q : pos_q + 1'b1;
      case (phase_q)
        PH_MAGIC1: begin
          if (!item_i.is_magic1) decided = 1'b1;
          else phase_d = PH_MAGIC2;
        end
        PH_MAGIC2: begin
          if (!item_i.is_magic2) decided = 1'b1;
          else phase_d = PH_METHOD;
        end
        PH_METHOD: begin
          if (!item_i.method_ok) decided = 1'b1;
          else phase_d = PH_FLAGS;
        end
        PH_FLAGS: begin
          if (!item_i.rsvd_ok) begin
            decided = 1'b1;
          end else begin
            flags_d = item_i.data[4:0];
            phase_d = PH_FIXED;
          end
        end
        PH_FIXED: begin
          if (len >= gzhp_pkg::FIXED_LEN) begin
            from_valid = 1'b1;
            from_ph    = PH_FIXED;
          end
        end
        PH_XLEN_LO: begin
          skip_d  = {8'h00, item_i.data};
          phase_d = PH_XLEN_HI;
        end
        PH_XLEN_HI: begin
          skip_d = {item_i.data, skip_q[7:0]};
          if (skip_d == 16'h0000) begin
            from_valid = 1'b1;
            from_ph    = PH_EXTRA;
          end else begin
            phase_d = PH_EXTRA;
          end
        end
        PH_EXTRA: begin
          skip_d = skip_dec;
          if (skip_dec == 16'h0000) begin
            from_valid = 1'b1;
            from_ph    = PH_EXTRA;
          end
        end
        PH_NAME: begin
          if (item_i.is_zero) begin
            from_valid = 1'b1;
            from_ph    = PH_NAME;
          end
        end
        PH_COMMENT: begin
          if (item_i.is_zero) begin
            from_valid = 1'b1;
            from_ph    = PH_COMMENT;
          end
        end
        PH_HCRC: begin
          skip_d = skip_dec;
          if (skip_dec == 16'h0000) complete = 1'b1;
        end
        default: begin
          decided = 1'b1;
        end
      endcase

      if (from_valid) begin
        if (nxt == PH_NONE) begin
          complete = 1'b1;
        end else begin
          phase_d = nxt;
          if (nxt == PH_HCRC) skip_d = 16'd2;
        end
      end

      if (!decided) begin
        if (len > {1'b0, scan_limit_i}) begin
          decided = 1'b1;
          status  = gzhp_pkg::STATUS_REJECT;
        end else if (complete) begin
          decided = 1'b1;
          status  = gzhp_pkg::STATUS_ACCEPT;
        end else if (item_i.last) begin
          decided = 1'b1;
          status  = (len < gzhp_pkg::FIXED_LEN) ? gzhp_pkg::STATUS_NOT_GZIP
                                                 : gzhp_pkg::STATUS_REJECT;
        end
      end

      if (decided) begin
        res_wr       = 1'b1;
        res_d.status = status;
        res_d.length = (status == gzhp_pkg::STATUS_ACCEPT) ? len[PB-1:0] : '0;
        res_d.flags  = (status == gzhp_pkg::STATUS_NOT_GZIP) ? 5'd0 : flags_d;
        verdict_d    = 1'b1;
      end
    end

    if (proc && item_i.last && (verdict_q || decided)) begin
      phase_d   = PH_MAGIC1;
      pos_d     = '0;
      skip_d    = '0;
      flags_d   = '0;
      verdict_d = 1'b0;
    end
  end

  assign empty_o  = (res_cnt_q == 2'd0);
  assign result_o = res_mem_q[res_rp_q];
  assign res_rd   = pop_i && !empty_o;

  always_comb begin
    res_cnt_d = res_cnt_q;
    if (res_wr && !res_rd) begin
      res_cnt_d = res_cnt_q + 1'b1;
    end else if (!res_wr && res_rd) begin
      res_cnt_d = res_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MAGIC1;
      pos_q     <= '0;
      skip_q    <= '0;
      flags_q   <= '0;
      verdict_q <= 1'b0;
      res_wp_q  <= 1'b0;
      res_rp_q  <= 1'b0;
      res_cnt_q <= '0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      skip_q    <= skip_d;
      flags_q   <= flags_d;
      verdict_q <= verdict_d;
      res_wp_q  <= res_wr ? !res_wp_q : res_wp_q;
      res_rp_q  <= res_rd ? !res_rp_q : res_rp_q;
      res_cnt_q <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_wr) begin
      res_mem_q[res_wp_q] <= res_d;
    end
  end

  a_res_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q != 2'd3)
    else $error("result buffer count out of range");

  a_no_result_after_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && verdict_q) |-> !res_wr)
    else $error("result produced after verdict");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_wr |-> ((res_d.status == gzhp_pkg::STATUS_NOT_GZIP) ||
                (res_d.status == gzhp_pkg::STATUS_ACCEPT) ||
                (res_d.status == gzhp_pkg::STATUS_REJECT)))
    else $error("illegal status code");

  a_length_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_wr && (res_d.status != gzhp_pkg::STATUS_ACCEPT)) |-> (res_d.length == '0))
    else $error("header length set without acceptance");

  a_verdict_clears_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && item_i.last) |=> !verdict_q)
    else $error("verdict not cleared at end of stream");

endmodule

// ===== rtl/core/gzip_header_parser.sv =====
// ---------------------------------------------------------------------------
// gzip_header_parser: gzip member header checker
// Reads a byte stream and reports one verdict per stream on the header.
//
//   Channel  Handshake        Payload
//   input    push_i / full_o  data_byte_i, last_byte_i
//   result   empty_o / pop_i  status_o, hdr_len_o, header_flags_o
//   config   scan_limit_we_i  scan_limit_i
//
// One byte is taken per cycle unless full_o is high; a verdict enters the result
// buffer as its deciding byte leaves the intake queue, which registers each pushed
// byte. The phase sequencer sets the rate: one byte per cycle, unless results stall.
// Reset empties both queues and sets the scan limit to 4096.
// A stalled result side fills the result buffer, then the intake queue,
// after which full_o is raised.
// ---------------------------------------------------------------------------
module gzip_header_parser (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  output logic                             full_o,
  input  logic [7:0]                       data_byte_i,
  input  logic                             last_byte_i,
  output logic                             empty_o,
  input  logic                             pop_i,
  output logic [1:0]                       status_o,
  output logic [15:0]                      hdr_len_o,
  output logic [4:0]                       header_flags_o,
  input  logic                             scan_limit_we_i,
  input  logic [gzhp_pkg::LIMIT_BITS-1:0]  scan_limit_i
);

  logic [gzhp_pkg::LIMIT_BITS-1:0] scan_limit_q;
  logic                            item_valid;
  logic                            item_take;
  gzhp_pkg::item_t                 item;
  gzhp_pkg::result_t               result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_limit_q <= gzhp_pkg::SCAN_LIMIT_RESET;
    end else if (scan_limit_we_i) begin
      scan_limit_q <= scan_limit_i;
    end
  end

  gzhp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  gzhp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scan_limit_i (scan_limit_q),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .item_i       (item),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .result_o     (result)
  );

  assign status_o       = result.status;
  assign hdr_len_o      = result.length;
  assign header_flags_o = result.flags;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the gzip header parser
// Feeds candidate gzip streams byte by byte, predicts each verdict in a small
// scoreboard class and compares every popped result field by field. Covers
// short directed streams, well-formed, truncated, corrupted and noise streams
// at several scan limits, and back-pressure on both sides.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES  = 300;

  localparam logic [4:0] FL_TEXT    = 5'h01;
  localparam logic [4:0] FL_HCRC    = 5'h02;
  localparam logic [4:0] FL_EXTRA   = 5'h04;
  localparam logic [4:0] FL_NAME    = 5'h08;
  localparam logic [4:0] FL_COMMENT = 5'h10;

  typedef enum logic [3:0] {
    PH_MAGIC1  = 4'd0,
    PH_MAGIC2  = 4'd1,
    PH_METHOD  = 4'd2,
    PH_FLAGS   = 4'd3,
    PH_FIXED   = 4'd4,
    PH_XLEN_LO = 4'd5,
    PH_XLEN_HI = 4'd6,
    PH_EXTRA   = 4'd7,
    PH_NAME    = 4'd8,
    PH_COMMENT = 4'd9,
    PH_HCRC    = 4'd10,
    PH_NONE    = 4'd15
  } parse_phase_e;

  class header_scoreboard;
    parse_phase_e                       phase;
    logic [gzhp_pkg::POSITION_BITS-1:0] position;
    logic [15:0]                        skip_left;
    logic [gzhp_pkg::LIMIT_BITS-1:0]    limit;
    logic [4:0]                         flags;
    bit                                 verdict_done;
    gzhp_pkg::result_t                  verdicts_q[$];
    int                                 errors;
    int                                 bytes_parsed;

    function new();
      limit        = gzhp_pkg::SCAN_LIMIT_RESET;
      errors       = 0;
      bytes_parsed = 0;
      restart();
    endfunction

    function void restart();
      phase        = PH_MAGIC1;
      position     = '0;
      skip_left    = '0;
      flags        = '0;
      verdict_done = 1'b0;
    endfunction

    function void set_limit(logic [gzhp_pkg::LIMIT_BITS-1:0] value);
      limit = value;
    endfunction

    function int pending();
      return verdicts_q.size();
    endfunction

    function parse_phase_e next_part(parse_phase_e after);
      if (after < PH_XLEN_LO && flags[2]) return PH_XLEN_LO;
      if (after < PH_NAME && flags[3]) return PH_NAME;
      if (after < PH_COMMENT && flags[4]) return PH_COMMENT;
      if (after < PH_HCRC && flags[1]) return PH_HCRC;
      return PH_NONE;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [gzhp_pkg::POSITION_BITS:0] len;
      logic [1:0]                       st;
      bit                               decided;
      bit                               complete;
      parse_phase_e                     from;
      parse_phase_e                     nxt;
      gzhp_pkg::result_t                res;
      decided  = 1'b0;
      complete = 1'b0;
      st       = gzhp_pkg::STATUS_NOT_GZIP;
      from     = PH_NONE;
      if (verdict_done) begin
        if (last) restart();
        return;
      end
      bytes_parsed++;
      len = {1'b0, position} + 1'b1;
      if (position != '1) position = position + 1'b1;
      case (phase)
        PH_MAGIC1: begin
          if (b != gzhp_pkg::MAGIC_FIRST) decided = 1'b1;
          else phase = PH_MAGIC2;
        end
        PH_MAGIC2: begin
          if (b != gzhp_pkg::MAGIC_SECOND) decided = 1'b1;
          else phase = PH_METHOD;
        end
        PH_METHOD: begin
          if (b[3:0] != gzhp_pkg::METHOD_DEFLATE) decided = 1'b1;
          else phase = PH_FLAGS;
        end
        PH_FLAGS: begin
          if (b[7:5] != 3'b000) begin
            decided = 1'b1;
          end else begin
            flags = b[4:0];
            phase = PH_FIXED;
          end
        end
        PH_FIXED: begin
          if (len >= gzhp_pkg::FIXED_LEN) from = PH_FIXED;
        end
        PH_XLEN_LO: begin
          skip_left = {8'h00, b};
          phase     = PH_XLEN_HI;
        end
        PH_XLEN_HI: begin
          skip_left = {b, skip_left[7:0]};
          if (skip_left == '0) from = PH_EXTRA;
          else phase = PH_EXTRA;
        end
        PH_EXTRA: begin
          skip_left = skip_left - 1'b1;
          if (skip_left == '0) from = PH_EXTRA;
        end
        PH_NAME: begin
          if (b == 8'h00) from = PH_NAME;
        end
        PH_COMMENT: begin
          if (b == 8'h00) from = PH_COMMENT;
        end
        PH_HCRC: begin
          skip_left = skip_left - 1'b1;
          if (skip_left == '0) complete = 1'b1;
        end
        default: begin
          decided = 1'b1;
        end
      endcase
      if (from != PH_NONE) begin
        nxt = next_part(from);
        if (nxt == PH_NONE) begin
          complete = 1'b1;
        end else begin
          phase = nxt;
          if (nxt == PH_HCRC) skip_left = 16'd2;
        end
      end
      if (!decided) begin
        if (len > {1'b0, limit}) begin
          st      = gzhp_pkg::STATUS_REJECT;
          decided = 1'b1;
        end else if (complete) begin
          st      = gzhp_pkg::STATUS_ACCEPT;
          decided = 1'b1;
        end else if (last) begin
          st      = (len < gzhp_pkg::FIXED_LEN) ? gzhp_pkg::STATUS_NOT_GZIP
                                                 : gzhp_pkg::STATUS_REJECT;
          decided = 1'b1;
        end
      end
      if (!decided) return;
      res.status = st;
      res.length = (st == gzhp_pkg::STATUS_ACCEPT) ? len[gzhp_pkg::POSITION_BITS-1:0] : '0;
      res.flags  = (st == gzhp_pkg::STATUS_NOT_GZIP) ? 5'h00 : flags;
      verdicts_q.push_back(res);
      verdict_done = 1'b1;
      if (last) restart();
    endfunction

    function void check_result(logic [1:0] st, logic [15:0] len, logic [4:0] fl);
      gzhp_pkg::result_t exp;
      if (verdicts_q.size() == 0) begin
        $display("%0t: unexpected verdict, status %0d length %0d flags %h",
                 $time, st, len, fl);
        errors++;
        return;
      end
      exp = verdicts_q.pop_front();
      if (st !== exp.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d", $time, exp.status, st);
        errors++;
      end
      if (len !== exp.length) begin
        $display("%0t: hdr_len mismatch, expected %0d, got %0d",
                 $time, exp.length, len);
        errors++;
      end
      if (fl !== exp.flags) begin
        $display("%0t: header_flags mismatch, expected %h, got %h", $time, exp.flags, fl);
        errors++;
      end
    endfunction
  endclass

  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            push_i          = 1'b0;
  logic                            full_o;
  logic [7:0]                      data_byte_i     = 8'h00;
  logic                            last_byte_i     = 1'b0;
  logic                            empty_o;
  logic                            pop_i           = 1'b0;
  logic [1:0]                      status_o;
  logic [15:0]                     hdr_len_o;
  logic [4:0]                      header_flags_o;
  logic                            scan_limit_we_i = 1'b0;
  logic [gzhp_pkg::LIMIT_BITS-1:0] scan_limit_i    = '0;

  header_scoreboard sb = new();
  logic [7:0]       stream_q[$];
  int               tx_idle_pct   = 13;
  int               rx_idle_pct   = 13;
  bit               hold_off_req  = 1'b0;
  int unsigned      cycle_count   = 0;

  gzip_header_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push_i),
    .full_o          (full_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .empty_o         (empty_o),
    .pop_i           (pop_i),
    .status_o        (status_o),
    .hdr_len_o       (hdr_len_o),
    .header_flags_o  (header_flags_o),
    .scan_limit_we_i (scan_limit_we_i),
    .scan_limit_i    (scan_limit_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push_i && !full_o) sb.note_byte(data_byte_i, last_byte_i);
      if (pop_i && !empty_o) sb.check_result(status_o, hdr_len_o, header_flags_o);
    end
  end

  // Result side: random pop requests, plus one long hold-off on demand.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        pop_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      pop_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i      <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
  endtask

  task automatic run_stream();
    foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
    stream_q.delete();
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [gzhp_pkg::LIMIT_BITS-1:0] value);
    push_i <= 1'b0;
    wait_drained();
    scan_limit_we_i <= 1'b1;
    scan_limit_i    <= value;
    @(posedge clk_i);
    scan_limit_we_i <= 1'b0;
    sb.set_limit(value);
  endtask

  function automatic void add_header(logic [4:0] fl, int xlen, int name_len,
                                     int comment_len, int payload);
    logic [15:0] xl;
    xl = 16'(xlen);
    stream_q.push_back(gzhp_pkg::MAGIC_FIRST);
    stream_q.push_back(gzhp_pkg::MAGIC_SECOND);
    stream_q.push_back({4'($urandom), gzhp_pkg::METHOD_DEFLATE});
    stream_q.push_back({3'b000, fl});
    repeat (6) stream_q.push_back(8'($urandom));
    if ((fl & FL_EXTRA) != 0) begin
      stream_q.push_back(xl[7:0]);
      stream_q.push_back(xl[15:8]);
      repeat (xlen) stream_q.push_back(8'($urandom));
    end
    if ((fl & FL_NAME) != 0) begin
      repeat (name_len) stream_q.push_back(8'($urandom_range(1, 255)));
      stream_q.push_back(8'h00);
    end
    if ((fl & FL_COMMENT) != 0) begin
      repeat (comment_len) stream_q.push_back(8'($urandom_range(1, 255)));
      stream_q.push_back(8'h00);
    end
    if ((fl & FL_HCRC) != 0) repeat (2) stream_q.push_back(8'($urandom));
    repeat (payload) stream_q.push_back(8'($urandom));
  endfunction

  // Mostly well-formed headers; the rest truncated, corrupted or plain noise.
  function automatic void make_random_stream();
    int kind;
    int cut;
    kind = $urandom_range(0, 99);
    if (kind < 88) begin
      add_header(5'($urandom),
                 ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) : $urandom_range(7, 40),
                 $urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 4));
      if (kind >= 64 && kind < 76) begin
        cut = $urandom_range(1, stream_q.size());
        while (stream_q.size() > cut) void'(stream_q.pop_back());
      end else if (kind >= 76) begin
        stream_q[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
      end
    end else begin
      repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom));
      if ($urandom_range(0, 1) != 0) stream_q[0] = gzhp_pkg::MAGIC_FIRST;
    end
  endfunction

  task automatic random_phase(input int target);
    int start;
    start = sb.bytes_parsed;
    while (sb.bytes_parsed - start < target) begin
      make_random_stream();
      run_stream();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_header(5'h00, 0, 0, 0, 2);
    run_stream();
    stream_q = '{8'h00};
    run_stream();
    stream_q = '{8'hFF, 8'h8B};
    run_stream();
    stream_q = '{gzhp_pkg::MAGIC_FIRST, 8'h00, 8'h08};
    run_stream();
    stream_q = '{gzhp_pkg::MAGIC_FIRST, gzhp_pkg::MAGIC_SECOND, 8'hF7};
    run_stream();
    stream_q = '{gzhp_pkg::MAGIC_FIRST, gzhp_pkg::MAGIC_SECOND, 8'h08, 8'hE0, 8'hFF, 8'h00};
    run_stream();
    stream_q = '{gzhp_pkg::MAGIC_FIRST, gzhp_pkg::MAGIC_SECOND, 8'h08, 8'h00, 8'h00};
    run_stream();
    // The name terminator is dropped, so the stream ends inside the name.
    add_header(FL_NAME, 0, 3, 0, 0);
    void'(stream_q.pop_back());
    run_stream();
    add_header(FL_EXTRA, 0, 0, 0, 1);
    run_stream();
    add_header(5'h1F, 300, 4, 2, 3);
    run_stream();
    add_header(FL_HCRC, 0, 0, 0, 0);
    run_stream();
    add_header(FL_NAME | FL_COMMENT | FL_TEXT, 0, 0, 0, 0);
    run_stream();
    add_header(FL_EXTRA, 2, 0, 0, 0);
    while (stream_q.size() > 10) void'(stream_q.pop_back());
    run_stream();
    add_header(FL_EXTRA, 2, 0, 0, 0);
    while (stream_q.size() > 9) void'(stream_q.pop_back());
    run_stream();

    hold_off_req = 1'b1;
    random_phase(120);

    write_limit(gzhp_pkg::LIMIT_BITS'(12));
    add_header(FL_HCRC, 0, 0, 0, 1);
    run_stream();
    add_header(FL_NAME, 0, 5, 0, 1);
    run_stream();
    random_phase(40);

    write_limit(gzhp_pkg::LIMIT_BITS'(11));
    add_header(FL_HCRC, 0, 0, 0, 0);
    run_stream();

    write_limit(gzhp_pkg::LIMIT_BITS'($urandom_range(13, 40)));
    random_phase(50);

    write_limit('1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(80);
    tx_idle_pct = 13;
    rx_idle_pct = 13;

    write_limit(gzhp_pkg::LIMIT_BITS'(8));
    add_header(FL_TEXT, 0, 0, 0, 2);
    run_stream();
    random_phase(30);

    write_limit(gzhp_pkg::LIMIT_BITS'($urandom_range(12, 65535)));
    random_phase(30);

    push_i <= 1'b0;
    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
